>>> design/mandel_pkg.sv
package mandel_pkg;

   localparam int VAL_W   = 40;
   localparam int COORD_W = 32;
   localparam int HALF_W  = 20;

   localparam logic signed [VAL_W-1:0] VAL_MAX      = 40'sh7F_FFFF_FFFF;
   localparam logic signed [VAL_W-1:0] VAL_MIN      = 40'sh80_0000_0000;
   localparam logic [VAL_W:0]          ESCAPE_LIMIT = 41'h001_0000_0000;

   localparam logic [7:0]  MAX_ITERATIONS_RESET = 8'd30;
   localparam logic [15:0] PALETTE_SCALE_RESET  = 16'd20;

   typedef enum logic [2:0] {
      REG_X_START        = 3'd0,
      REG_Y_START        = 3'd1,
      REG_X_STEP         = 3'd2,
      REG_Y_STEP         = 3'd3,
      REG_MAX_ITERATIONS = 3'd4,
      REG_PALETTE_SCALE  = 3'd5
   } reg_index_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_MUL,
      BACK_SUM,
      BACK_UPDATE,
      BACK_FINISH
   } back_state_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x_start;
      logic signed [COORD_W-1:0] y_start;
      logic signed [COORD_W-1:0] x_step;
      logic signed [COORD_W-1:0] y_step;
      logic [7:0]                max_iterations;
      logic [15:0]               palette_scale;
   } cfg_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] cx;
      logic signed [VAL_W-1:0] cy;
   } queue_entry_type;

   // clamp a wide signed sum to the 40-bit internal range
   function automatic logic signed [VAL_W-1:0] sat40(input logic signed [63:0] v);
      logic signed [VAL_W-1:0] r;
      if (v > 64'(VAL_MAX)) begin
         r = VAL_MAX;
      end else if (v < 64'(VAL_MIN)) begin
         r = VAL_MIN;
      end else begin
         r = v[VAL_W-1:0];
      end
      return r;
   endfunction

   // join 20x20 partial products into the magnitude product shifted right by 28
   function automatic logic [52:0] combine_mag(input logic [39:0] hh,
                                               input logic [41:0] mid,
                                               input logic [39:0] ll);
      logic [62:0] low_sum;
      low_sum = 63'({mid, 20'b0}) + 63'(ll);
      return 53'({hh, 12'b0}) + 53'(low_sum[62:28]);
   endfunction

   function automatic logic signed [VAL_W-1:0] sat_pos(input logic [52:0] mag);
      logic signed [VAL_W-1:0] r;
      if (mag > 53'(VAL_MAX)) begin
         r = VAL_MAX;
      end else begin
         r = mag[VAL_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [VAL_W-1:0] sat_neg(input logic [52:0] mag);
      logic signed [VAL_W-1:0] r;
      if (mag > 53'h80_0000_0000) begin
         r = VAL_MIN;
      end else begin
         r = 40'(53'd0 - mag);
      end
      return r;
   endfunction

endpackage

>>> design/mandel_if.sv
interface mandel_req_if;
   logic       valid;
   logic       ready;
   logic [8:0] column;
   logic [8:0] row;

   modport source (output valid, output column, output row, input ready);
   modport sink (input valid, input column, input row, output ready);
endinterface

interface mandel_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] iterations;

   modport source (output valid, output red, output green, output blue,
                   output iterations, input ready);
   modport sink (input valid, input red, input green, input blue,
                 input iterations, output ready);
endinterface

>>> design/mandelbrot_escape_time_pixel_unit.sv
// Mandelbrot escape-time pixel unit.
// req_chan carries one pixel (column, row) per transaction; rsp_chan returns one
// transaction per pixel, in order, with the colour bytes and the iteration count.
// Both channels move a transaction on a clock edge with valid and ready high.
// The csr_ port is APB style, pready always high: x_start, y_start, x_step,
// y_step, max_iterations and palette_scale at byte addresses 0,4,...,20.
// Change registers only while no pixel is in flight.
// The front stage forms c from the registers and pushes it into a short queue;
// the back engine pops one pixel at a time and runs the iteration loop through
// its partial products, combine and update states until the pixel escapes or
// reaches the limit, then hands the result over in the finish state.
// While the engine works, the front takes pixels until it and the queue are full.
// When rsp_chan stalls, the finished result holds in the output register, the
// engine holds the next one, and req_chan.ready falls once queue and front fill.
// Reset is synchronous: registers return to zero with a limit of 30 and a
// palette scale of 20, the queue empties and no result is pending.
module mandelbrot_escape_time_pixel_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   mandel_req_if.sink  req_chan,
   mandel_rsp_if.source rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import mandel_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   logic            csr_write;
   logic            q_push, q_pop, q_full, q_empty;
   queue_entry_type push_entry, pop_entry;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_paddr[4:2])
            REG_X_START:        cfg_in.x_start        = csr_pwdata;
            REG_Y_START:        cfg_in.y_start        = csr_pwdata;
            REG_X_STEP:         cfg_in.x_step         = csr_pwdata;
            REG_Y_STEP:         cfg_in.y_step         = csr_pwdata;
            REG_MAX_ITERATIONS: cfg_in.max_iterations = csr_pwdata[7:0];
            REG_PALETTE_SCALE:  cfg_in.palette_scale  = csr_pwdata[15:0];
            default: begin
               // drop writes to unmapped addresses
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         REG_X_START:        csr_prdata = cfg_ff.x_start;
         REG_Y_START:        csr_prdata = cfg_ff.y_start;
         REG_X_STEP:         csr_prdata = cfg_ff.x_step;
         REG_Y_STEP:         csr_prdata = cfg_ff.y_step;
         REG_MAX_ITERATIONS: csr_prdata = 32'(cfg_ff.max_iterations);
         REG_PALETTE_SCALE:  csr_prdata = 32'(cfg_ff.palette_scale);
         default:            csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_start        <= '0;
         cfg_ff.y_start        <= '0;
         cfg_ff.x_step         <= '0;
         cfg_ff.y_step         <= '0;
         cfg_ff.max_iterations <= MAX_ITERATIONS_RESET;
         cfg_ff.palette_scale  <= PALETTE_SCALE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mandel_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (push_entry)
   );

   mandel_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .empty      (q_empty)
   );

   mandel_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_empty  (q_empty),
      .q_entry  (pop_entry),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> design/mandel_front.sv
module mandel_front (
   input  logic                         clock,
   input  logic                         reset,
   input  mandel_pkg::cfg_type          cfg,
   mandel_req_if.sink                   req_chan,
   input  logic                         q_full,
   output logic                         q_push,
   output mandel_pkg::queue_entry_type  q_entry
);
   import mandel_pkg::*;

   logic       valid_ff, valid_in;
   logic [8:0] col_ff, row_ff;
   logic       accept;

   logic signed [41:0] px, py;

   assign req_chan.ready = !valid_ff || !q_full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign q_push         = valid_ff && !q_full;
   assign valid_in       = accept || (valid_ff && q_full);

   always_comb begin
      px = $signed({1'b0, col_ff}) * cfg.x_step;
      py = $signed({1'b0, row_ff}) * cfg.y_step;
      q_entry.cx = sat40(64'(px) + 64'(cfg.x_start));
      q_entry.cy = sat40(64'(py) + 64'(cfg.y_start));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         col_ff <= req_chan.column;
         row_ff <= req_chan.row;
      end
   end

endmodule

>>> design/mandel_queue.sv
module mandel_queue #(
   parameter int DEPTH = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  mandel_pkg::queue_entry_type  push_entry,
   output logic                         full,
   input  logic                         pop,
   output mandel_pkg::queue_entry_type  pop_entry,
   output logic                         empty
);
   import mandel_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   queue_entry_type mem [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < CNT_W'(DEPTH)) || pop)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue pop while empty");

endmodule

>>> design/mandel_back.sv
module mandel_back (
   input  logic                         clock,
   input  logic                         reset,
   input  mandel_pkg::cfg_type          cfg,
   input  logic                         q_empty,
   input  mandel_pkg::queue_entry_type  q_entry,
   output logic                         q_pop,
   mandel_rsp_if.source                 rsp_chan
);
   import mandel_pkg::*;

   back_state_type state_ff, state_in;
   logic [7:0]     n_ff, n_in;
   logic [7:0]     limit_ff, limit_in;
   logic           rsp_valid_ff, rsp_valid_in;

   logic signed [VAL_W-1:0] cx_ff, cy_ff, zx_ff, zy_ff;
   logic signed [VAL_W-1:0] zx2_ff, zy2_ff, zxy_ff;
   logic signed [VAL_W-1:0] zx2_in, zy2_in, zxy_in, zx_in, zy_in;

   logic [39:0] xx_hh_ff, xx_hl_ff, xx_ll_ff;
   logic [39:0] yy_hh_ff, yy_hl_ff, yy_ll_ff;
   logic [39:0] xy_hh_ff, xy_hl_ff, xy_lh_ff, xy_ll_ff;
   logic [39:0] xx_hh_in, xx_hl_in, xx_ll_in;
   logic [39:0] yy_hh_in, yy_hl_in, yy_ll_in;
   logic [39:0] xy_hh_in, xy_hl_in, xy_lh_in, xy_ll_in;
   logic        xy_neg_ff;

   logic [VAL_W-1:0] ax, ay;
   logic [52:0]      xx_mag, yy_mag, xy_mag;
   logic signed [VAL_W-1:0] xy_prod;
   logic [VAL_W:0]   esc_sum;
   logic             escape;
   logic [23:0]      colour;

   logic load_c, load_part, load_prod, load_z, load_rsp;

   logic [7:0] red_ff, green_ff, blue_ff, iter_ff;

   // multiply stage: magnitudes split in halves, ten 20x20 partials
   always_comb begin
      ax = zx_ff[VAL_W-1] ? (40'd0 - zx_ff) : zx_ff;
      ay = zy_ff[VAL_W-1] ? (40'd0 - zy_ff) : zy_ff;
      xx_hh_in = ax[39:20] * ax[39:20];
      xx_hl_in = ax[39:20] * ax[19:0];
      xx_ll_in = ax[19:0] * ax[19:0];
      yy_hh_in = ay[39:20] * ay[39:20];
      yy_hl_in = ay[39:20] * ay[19:0];
      yy_ll_in = ay[19:0] * ay[19:0];
      xy_hh_in = ax[39:20] * ay[39:20];
      xy_hl_in = ax[39:20] * ay[19:0];
      xy_lh_in = ax[19:0] * ay[39:20];
      xy_ll_in = ax[19:0] * ay[19:0];
   end

   // combine stage: truncated magnitudes, sign, saturate, double the cross term
   always_comb begin
      xx_mag  = combine_mag(xx_hh_ff, 42'({xx_hl_ff, 1'b0}), xx_ll_ff);
      yy_mag  = combine_mag(yy_hh_ff, 42'({yy_hl_ff, 1'b0}), yy_ll_ff);
      xy_mag  = combine_mag(xy_hh_ff, 42'(xy_hl_ff) + 42'(xy_lh_ff), xy_ll_ff);
      zx2_in  = sat_pos(xx_mag);
      zy2_in  = sat_pos(yy_mag);
      xy_prod = xy_neg_ff ? sat_neg(xy_mag) : sat_pos(xy_mag);
      zxy_in  = sat40(64'(xy_prod) + 64'(xy_prod));
   end

   // update stage: new z and escape test on the old squares
   always_comb begin
      zx_in   = sat40(64'(zx2_ff) - 64'(zy2_ff) + 64'(cx_ff));
      zy_in   = sat40(64'(zxy_ff) + 64'(cy_ff));
      esc_sum = {1'b0, zx2_ff} + {1'b0, zy2_ff};
      escape  = esc_sum > ESCAPE_LIMIT;
      colour  = 24'(n_ff) * 24'(cfg.palette_scale);
   end

   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      limit_in  = limit_ff;
      q_pop     = 1'b0;
      load_c    = 1'b0;
      load_part = 1'b0;
      load_prod = 1'b0;
      load_z    = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               load_c   = 1'b1;
               n_in     = 8'd0;
               limit_in = cfg.max_iterations;
               state_in = (cfg.max_iterations == 8'd0) ? BACK_FINISH : BACK_MUL;
            end
         end
         BACK_MUL: begin
            load_part = 1'b1;
            state_in  = BACK_SUM;
         end
         BACK_SUM: begin
            load_prod = 1'b1;
            state_in  = BACK_UPDATE;
         end
         BACK_UPDATE: begin
            load_z = 1'b1;
            if (escape) begin
               state_in = BACK_FINISH;
            end else begin
               n_in     = n_ff + 8'd1;
               state_in = (n_ff + 8'd1 == limit_ff) ? BACK_FINISH : BACK_MUL;
            end
         end
         BACK_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_rsp = 1'b1;
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
      rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         n_ff         <= 8'd0;
         limit_ff     <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_c) begin
         cx_ff <= q_entry.cx;
         cy_ff <= q_entry.cy;
         zx_ff <= q_entry.cx;
         zy_ff <= q_entry.cy;
      end else if (load_z) begin
         zx_ff <= zx_in;
         zy_ff <= zy_in;
      end
      if (load_part) begin
         xx_hh_ff  <= xx_hh_in;
         xx_hl_ff  <= xx_hl_in;
         xx_ll_ff  <= xx_ll_in;
         yy_hh_ff  <= yy_hh_in;
         yy_hl_ff  <= yy_hl_in;
         yy_ll_ff  <= yy_ll_in;
         xy_hh_ff  <= xy_hh_in;
         xy_hl_ff  <= xy_hl_in;
         xy_lh_ff  <= xy_lh_in;
         xy_ll_ff  <= xy_ll_in;
         xy_neg_ff <= zx_ff[VAL_W-1] ^ zy_ff[VAL_W-1];
      end
      if (load_prod) begin
         zx2_ff <= zx2_in;
         zy2_ff <= zy2_in;
         zxy_ff <= zxy_in;
      end
      if (load_rsp) begin
         red_ff   <= colour[23:16];
         green_ff <= colour[15:8];
         blue_ff  <= colour[7:0];
         iter_ff  <= n_ff;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.red        = red_ff;
   assign rsp_chan.green      = green_ff;
   assign rsp_chan.blue       = blue_ff;
   assign rsp_chan.iterations = iter_ff;

   a_count_in_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff != BACK_IDLE) |-> n_ff <= limit_ff)
      else $error("iteration count beyond limit");

   a_squares_nonneg: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_UPDATE) |-> !zx2_ff[VAL_W-1] && !zy2_ff[VAL_W-1])
      else $error("negative square in update");

endmodule
